// File: hdl/accel_tilt_angle_macros.svh
// assertion helpers shared by the tilt angle rtl
`ifndef ACCEL_TILT_ANGLE_MACROS_SVH
`define ACCEL_TILT_ANGLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ATA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ATA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ata_pkg.sv
package ata_pkg;

    // sample and fixed point layout
    localparam int SAMPLE_W   = 16;
    localparam int SEL_W      = 2;
    localparam int FRAC_SHIFT = 8;
    localparam int MAG_W      = SAMPLE_W;
    localparam int PLAIN_W    = MAG_W + FRAC_SHIFT;
    localparam int SUM_W      = 2 * MAG_W;
    localparam int RAD_W      = SUM_W + 2 * FRAC_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQ_STAGES  = ROOT_W / 2;
    localparam int REM_W      = ROOT_W + 3;

    // cordic
    localparam int CIN_W        = ROOT_W;
    localparam int CW           = CIN_W + 4;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int Q_FRAC       = 16;
    localparam int ANG_W        = Q_FRAC + 2;
    localparam int ANGC_W       = Q_FRAC + 1;
    localparam logic [ANGC_W-1:0] HALF_PI_Q16 = ANGC_W'(102944);

    // radians to tenths of a degree: * 90000 / (157 * 2^16)
    localparam int SCALE_NUM_W = 17;
    localparam logic [SCALE_NUM_W-1:0] SCALE_NUM = SCALE_NUM_W'(90000);
    localparam int SCALE_DEN   = 157;
    localparam int PROD1_W     = ANGC_W + SCALE_NUM_W;
    localparam int T_W         = PROD1_W - Q_FRAC;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SCALE_DEN - 1) / SCALE_DEN);
    localparam int PROD2_W     = T_W + RECIP_W;

    // result
    localparam int OUT_W       = 11;
    localparam int IN_TDATA_W  = 3 * SAMPLE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam logic signed [OUT_W-1:0] TENTHS_LIM = OUT_W'(900);

    typedef enum logic [SEL_W-1:0] {
        AXIS_Z    = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // per-sample control carried alongside the datapath
    typedef struct packed {
        logic num_zero;
        logic den_zero;
        logic neg;
        logic root_is_num;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    // atan(2^-i) in q16, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            4'd0:  v = ANG_W'(51472);
            4'd1:  v = ANG_W'(30386);
            4'd2:  v = ANG_W'(16055);
            4'd3:  v = ANG_W'(8150);
            4'd4:  v = ANG_W'(4091);
            4'd5:  v = ANG_W'(2047);
            4'd6:  v = ANG_W'(1024);
            4'd7:  v = ANG_W'(512);
            4'd8:  v = ANG_W'(256);
            4'd9:  v = ANG_W'(128);
            4'd10: v = ANG_W'(64);
            4'd11: v = ANG_W'(32);
            4'd12: v = ANG_W'(16);
            4'd13: v = ANG_W'(8);
            4'd14: v = ANG_W'(4);
            4'd15: v = ANG_W'(2);
        endcase
        return v;
    endfunction

endpackage

// File: hdl/ata_front.sv
module ata_front
    import ata_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic signed [SAMPLE_W-1:0] i_y,
    input  logic signed [SAMPLE_W-1:0] i_z,
    input  logic [SEL_W-1:0]           i_sel,
    output logic                       o_valid,
    output t_side                      o_side,
    output logic [PLAIN_W-1:0]         o_plain,
    output logic [SUM_W-1:0]           o_sum
);

    function automatic logic [MAG_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    logic [MAG_W-1:0]   w_mx, w_my, w_mz;
    logic               w_zx, w_zy, w_zz;

    logic [MAG_W-1:0]   n1_a, n1_b, n1_plain;
    t_side              n1_side;
    logic               r1_v;
    logic [MAG_W-1:0]   r1_a, r1_b;
    logic [PLAIN_W-1:0] r1_plain;
    t_side              r1_side;

    logic               r2_v;
    logic [SUM_W-1:0]   r2_sqa, r2_sqb;
    logic [PLAIN_W-1:0] r2_plain;
    t_side              r2_side;

    logic               r3_v;
    logic [SUM_W-1:0]   r3_sum;
    logic [PLAIN_W-1:0] r3_plain;
    t_side              r3_side;

    assign w_mx = mag(i_x);
    assign w_my = mag(i_y);
    assign w_mz = mag(i_z);
    assign w_zx = (i_x == '0);
    assign w_zy = (i_y == '0);
    assign w_zz = (i_z == '0);

    // pick the pair under the root and the plain operand
    always_comb begin
        unique case (t_axis'(i_sel))
            AXIS_Z: begin
                n1_a     = w_mx;
                n1_b     = w_my;
                n1_plain = w_mz;
                n1_side  = '{num_zero: w_zx & w_zy, den_zero: w_zz,
                             neg: i_z[SAMPLE_W-1], root_is_num: 1'b1};
            end
            AXIS_X: begin
                n1_a     = w_my;
                n1_b     = w_mz;
                n1_plain = w_mx;
                n1_side  = '{num_zero: w_zx, den_zero: w_zy & w_zz,
                             neg: i_x[SAMPLE_W-1], root_is_num: 1'b0};
            end
            AXIS_Y: begin
                n1_a     = w_mx;
                n1_b     = w_mz;
                n1_plain = w_my;
                n1_side  = '{num_zero: w_zy, den_zero: w_zx & w_zz,
                             neg: i_y[SAMPLE_W-1], root_is_num: 1'b0};
            end
            AXIS_NONE: begin
                n1_a     = '0;
                n1_b     = '0;
                n1_plain = '0;
                n1_side  = '{num_zero: 1'b1, den_zero: 1'b0,
                             neg: 1'b0, root_is_num: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= n1_a;
            r1_b     <= n1_b;
            r1_plain <= {n1_plain, {FRAC_SHIFT{1'b0}}};
            r1_side  <= n1_side;

            r2_sqa   <= SUM_W'(r1_a) * SUM_W'(r1_a);
            r2_sqb   <= SUM_W'(r1_b) * SUM_W'(r1_b);
            r2_plain <= r1_plain;
            r2_side  <= r1_side;

            r3_sum   <= r2_sqa + r2_sqb;
            r3_plain <= r2_plain;
            r3_side  <= r2_side;
        end
    end

    assign o_valid = r3_v;
    assign o_side  = r3_side;
    assign o_plain = r3_plain;
    assign o_sum   = r3_sum;

endmodule

// File: hdl/ata_isqrt.sv
module ata_isqrt
    import ata_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic [PLAIN_W-1:0] i_plain,
    input  logic [SUM_W-1:0]   i_sum,
    output logic               o_valid,
    output t_side              o_side,
    output logic [PLAIN_W-1:0] o_plain,
    output logic [ROOT_W-1:0]  o_root
);

    // one restoring digit: two radicand bits in, one root bit out
    function automatic t_sq sq_step(input t_sq s, input logic [1:0] b);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        t_sq              o;
        r     = {s.rem[REM_W-3:0], b};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        if (r >= trial) begin
            o.rem  = r - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic               r_v     [SQ_STAGES];
    t_side              r_side  [SQ_STAGES];
    logic [PLAIN_W-1:0] r_plain [SQ_STAGES];
    logic [RAD_W-1:0]   r_rad   [SQ_STAGES];
    t_sq                r_sq    [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
        logic               w_v;
        t_side              w_side;
        logic [PLAIN_W-1:0] w_plain;
        logic [RAD_W-1:0]   w_rad;
        t_sq                w_sq;
        t_sq                n_mid;
        t_sq                n_sq;

        if (g == 0) begin : g_first
            assign w_v     = i_valid;
            assign w_side  = i_side;
            assign w_plain = i_plain;
            assign w_rad   = {i_sum, {(2*FRAC_SHIFT){1'b0}}};
            assign w_sq    = '0;
        end else begin : g_rest
            assign w_v     = r_v[g-1];
            assign w_side  = r_side[g-1];
            assign w_plain = r_plain[g-1];
            assign w_rad   = r_rad[g-1];
            assign w_sq    = r_sq[g-1];
        end

        always_comb begin
            n_mid = sq_step(w_sq, w_rad[RAD_W-1 -: 2]);
            n_sq  = sq_step(n_mid, w_rad[RAD_W-3 -: 2]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g]  <= w_side;
                r_plain[g] <= w_plain;
                r_rad[g]   <= {w_rad[RAD_W-5:0], 4'b0000};
                r_sq[g]    <= n_sq;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];
    assign o_plain = r_plain[SQ_STAGES-1];
    assign o_root  = r_sq[SQ_STAGES-1].root;

endmodule

// File: hdl/ata_cordic.sv
module ata_cordic
    import ata_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_side                   i_side,
    input  logic [CIN_W-1:0]        i_px,
    input  logic [CIN_W-1:0]        i_py,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic signed [ANG_W-1:0] o_ang
);

    logic                    r_v   [CORDIC_STEPS];
    t_side                   r_side[CORDIC_STEPS];
    logic signed [CW-1:0]    r_cx  [CORDIC_STEPS];
    logic signed [CW-1:0]    r_cy  [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_ang [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_st
        logic                    w_v;
        t_side                   w_side;
        logic signed [CW-1:0]    w_cx, w_cy;
        logic signed [ANG_W-1:0] w_ang;
        logic signed [CW-1:0]    w_dx, w_dy;
        logic signed [ANG_W-1:0] w_step;
        logic signed [CW-1:0]    n_cx, n_cy;
        logic signed [ANG_W-1:0] n_ang;

        if (g == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_side = i_side;
            assign w_cx   = $signed({{(CW-CIN_W){1'b0}}, i_px});
            assign w_cy   = $signed({{(CW-CIN_W){1'b0}}, i_py});
            assign w_ang  = '0;
        end else begin : g_rest
            assign w_v    = r_v[g-1];
            assign w_side = r_side[g-1];
            assign w_cx   = r_cx[g-1];
            assign w_cy   = r_cy[g-1];
            assign w_ang  = r_ang[g-1];
        end

        assign w_dx   = w_cy >>> g;
        assign w_dy   = w_cx >>> g;
        assign w_step = atan_q16(STEP_W'(g));

        // rotate towards the x axis; y at zero counts as not positive
        always_comb begin
            if (!w_cy[CW-1] && (w_cy != '0)) begin
                n_cx  = w_cx + w_dx;
                n_cy  = w_cy - w_dy;
                n_ang = w_ang + w_step;
            end else begin
                n_cx  = w_cx - w_dx;
                n_cy  = w_cy + w_dy;
                n_ang = w_ang - w_step;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_side;
                r_cx[g]   <= n_cx;
                r_cy[g]   <= n_cy;
                r_ang[g]  <= n_ang;
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_side  = r_side[CORDIC_STEPS-1];
    assign o_ang   = r_ang[CORDIC_STEPS-1];

endmodule

// File: hdl/ata_scale.sv
module ata_scale
    import ata_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_side                   i_side,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_tenths,
    output logic                    o_flag
);

    logic [ANGC_W-1:0]       w_angc;
    logic [OUT_W-1:0]        w_mag;

    logic                    r_a_v, r_b_v, r_c_v;
    t_side                   r_a_side, r_b_side;
    logic [PROD1_W-1:0]      r_a_p;
    logic [PROD2_W-1:0]      r_b_p;
    logic signed [OUT_W-1:0] r_c_tenths;
    logic                    r_c_flag;

    // special cases first, then clamp to [0, pi/2]
    always_comb begin
        priority if (i_side.num_zero) begin
            w_angc = '0;
        end else if (i_side.den_zero) begin
            w_angc = HALF_PI_Q16;
        end else if (i_ang[ANG_W-1]) begin
            w_angc = '0;
        end else if ($unsigned(i_ang) > {{(ANG_W-ANGC_W){1'b0}}, HALF_PI_Q16}) begin
            w_angc = HALF_PI_Q16;
        end else begin
            w_angc = i_ang[ANGC_W-1:0];
        end
    end

    // floor(t / 157) as t * ceil(2^27 / 157) >> 27, exact over the t range
    assign w_mag = OUT_W'(r_b_p >> RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p      <= PROD1_W'(w_angc) * PROD1_W'(SCALE_NUM);
            r_a_side   <= i_side;
            r_b_p      <= PROD2_W'(r_a_p[PROD1_W-1:Q_FRAC]) * PROD2_W'(RECIP);
            r_b_side   <= r_a_side;
            r_c_tenths <= r_b_side.neg ? -$signed(w_mag) : $signed(w_mag);
            r_c_flag   <= r_b_side.num_zero & r_b_side.den_zero;
        end
    end

    assign o_valid  = r_c_v;
    assign o_tenths = r_c_tenths;
    assign o_flag   = r_c_flag;

endmodule

// File: hdl/accel_tilt_angle.sv
// Tilt angle of a three-axis accelerometer sample, in tenths of a degree.
// A beat on the slave side carries x, y, z and an axis selector; selector 0
// gives the angle to Z, atan(sqrt(x^2+y^2)/z), 1 the angle to X,
// atan(x/sqrt(y^2+z^2)), 2 the angle to Y, and 3 returns zero. Radians are
// scaled by 1800/3.14 and truncated towards zero, so results lie in
// -900..900. A zero denominator gives +-900 by the sign of the numerator;
// both terms zero gives 0 with tuser set. The pipeline is 34 register
// stages long (3 for squares and sum, 12 for the root at two bits a stage,
// 16 CORDIC iterations, 3 for clamping and the scale multiplies); the
// first stage loads on the edge that takes the sample, and the result then
// passes through the output register before it is presented. One sample is
// taken every cycle; the rate is set by the single pipeline enable, which
// drops only while the one-entry skid buffer behind the output register
// holds a result.
module accel_tilt_angle
    import ata_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // axis_select [1:0]
    input  logic [SEL_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // angle_tenths [10:0], zero padding [15:11]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // undefined_ratio [0]
    output logic                   o_m_axis_tuser
);

    `include "accel_tilt_angle_macros.svh"

    // whole pipeline moves together; it halts only when the skid is full
    logic                    w_en;

    // front end: magnitudes, squares, sum
    logic                    w_fr_v;
    t_side                   w_fr_side;
    logic [PLAIN_W-1:0]      w_fr_plain;
    logic [SUM_W-1:0]        w_fr_sum;

    // root
    logic                    w_sq_v;
    t_side                   w_sq_side;
    logic [PLAIN_W-1:0]      w_sq_plain;
    logic [ROOT_W-1:0]       w_sq_root;

    // cordic operands: x is |den|, y is |num|
    logic [CIN_W-1:0]        w_px, w_py;
    logic                    w_co_v;
    t_side                   w_co_side;
    logic signed [ANG_W-1:0] w_co_ang;

    // last pipeline stage
    logic                    w_pipe_v;
    logic signed [OUT_W-1:0] w_pipe_tenths;
    logic                    w_pipe_flag;

    // output register and skid buffer
    logic                    w_take;
    logic                    r_out_v, n_out_v;
    logic signed [OUT_W-1:0] r_out_tenths, n_out_tenths;
    logic                    r_out_flag, n_out_flag;
    logic                    r_skid_v, n_skid_v;
    logic signed [OUT_W-1:0] r_skid_tenths, n_skid_tenths;
    logic                    r_skid_flag, n_skid_flag;

    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;

    ata_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_x     ($signed(i_s_axis_tdata[SAMPLE_W-1:0])),
        .i_y     ($signed(i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .i_z     ($signed(i_s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W])),
        .i_sel   (i_s_axis_tuser),
        .o_valid (w_fr_v),
        .o_side  (w_fr_side),
        .o_plain (w_fr_plain),
        .o_sum   (w_fr_sum)
    );

    ata_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_v),
        .i_side  (w_fr_side),
        .i_plain (w_fr_plain),
        .i_sum   (w_fr_sum),
        .o_valid (w_sq_v),
        .o_side  (w_sq_side),
        .o_plain (w_sq_plain),
        .o_root  (w_sq_root)
    );

    // for the angle to Z the root is the numerator, otherwise the denominator
    assign w_px = w_sq_side.root_is_num ? CIN_W'(w_sq_plain) : CIN_W'(w_sq_root);
    assign w_py = w_sq_side.root_is_num ? CIN_W'(w_sq_root)  : CIN_W'(w_sq_plain);

    ata_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_side  (w_sq_side),
        .i_px    (w_px),
        .i_py    (w_py),
        .o_valid (w_co_v),
        .o_side  (w_co_side),
        .o_ang   (w_co_ang)
    );

    ata_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_co_v),
        .i_side   (w_co_side),
        .i_ang    (w_co_ang),
        .o_valid  (w_pipe_v),
        .o_tenths (w_pipe_tenths),
        .o_flag   (w_pipe_flag)
    );

    // output side: the pipeline keeps running while a result waits, and
    // the one result that arrives behind it parks in the skid
    assign w_take = r_out_v && i_m_axis_tready;

    always_comb begin
        n_out_v       = r_out_v;
        n_out_tenths  = r_out_tenths;
        n_out_flag    = r_out_flag;
        n_skid_v      = r_skid_v;
        n_skid_tenths = r_skid_tenths;
        n_skid_flag   = r_skid_flag;
        priority if (r_skid_v) begin
            // pipeline is halted, drain the skid into the output register
            if (w_take) begin
                n_out_tenths = r_skid_tenths;
                n_out_flag   = r_skid_flag;
                n_skid_v     = 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            n_out_v      = w_pipe_v;
            n_out_tenths = w_pipe_tenths;
            n_out_flag   = w_pipe_flag;
        end else if (w_pipe_v) begin
            n_skid_v      = 1'b1;
            n_skid_tenths = w_pipe_tenths;
            n_skid_flag   = w_pipe_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tenths  <= n_out_tenths;
        r_out_flag    <= n_out_flag;
        r_skid_tenths <= n_skid_tenths;
        r_skid_flag   <= n_skid_flag;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_out_tenths};
    assign o_m_axis_tuser  = r_out_flag;

    // angle never leaves the quarter turn
    `ATA_ASSERT_IMP(a_angle_range, r_out_v,
                    (r_out_tenths <= TENTHS_LIM) && (r_out_tenths >= -TENTHS_LIM),
                    "angle out of range")
    // an undefined ratio always comes with a zero angle
    `ATA_ASSERT_IMP(a_flag_zero, r_out_v && r_out_flag, r_out_tenths == '0,
                    "flagged beat with nonzero angle")
    // the skid only fills behind a waiting result
    `ATA_ASSERT_IMP(a_skid_order, r_skid_v, r_out_v, "skid holds data with output empty")
    // a result arriving at a stalled output is caught by the skid
    `ATA_ASSERT_NXT(a_skid_catch, r_out_v && !i_m_axis_tready && !r_skid_v && w_pipe_v,
                    r_skid_v, "result lost at stalled output")

endmodule
